[hdl/lrs_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrs_pkg
// Types, codes and reset values shared by the link recovery supervisor.
// ----------------------------------------------------------------------------
package lrs_pkg;

    localparam int unsigned TS_W    = 32;
    localparam int unsigned CNT_W   = 8;
    localparam int unsigned CMD_W   = 2;
    localparam int unsigned LINK_W  = 2;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DATA_W = 32;
    localparam int unsigned S_TDATA_W = 40;
    localparam int unsigned S_TUSER_W = 2;
    localparam int unsigned M_TDATA_W = 16;

    localparam logic [TS_W-1:0] HEALTH_INTERVAL_MS = 32'd300000;

    // commands
    localparam logic [CMD_W-1:0] CMD_TICK    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_BEGIN   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_PUBLISH = 2'd2;

    // link states
    localparam logic [LINK_W-1:0] LINK_RADIO_DOWN  = 2'd0;
    localparam logic [LINK_W-1:0] LINK_INET_DOWN   = 2'd1;
    localparam logic [LINK_W-1:0] LINK_BROKER_DOWN = 2'd2;
    localparam logic [LINK_W-1:0] LINK_UP          = 2'd3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_RADIO_RETRY    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INET_RETRY     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INET_CHECK     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BROKER_RETRY   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_WATCHDOG       = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_BROKER_LIMIT   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_RADIO_LIMIT    = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_BROKER_TOTAL   = 3'd7;

    // configuration reset values
    localparam logic [TS_W-1:0]  RST_RADIO_RETRY  = 32'd30000;
    localparam logic [TS_W-1:0]  RST_INET_RETRY   = 32'd10000;
    localparam logic [TS_W-1:0]  RST_INET_CHECK   = 32'd300000;
    localparam logic [TS_W-1:0]  RST_BROKER_RETRY = 32'd10000;
    localparam logic [TS_W-1:0]  RST_WATCHDOG     = 32'd600000;
    localparam logic [CNT_W-1:0] RST_BROKER_LIMIT = 8'd3;
    localparam logic [CNT_W-1:0] RST_RADIO_LIMIT  = 8'd3;
    localparam logic [CNT_W-1:0] RST_BROKER_TOTAL = 8'd9;

    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    typedef struct packed {
        logic [TS_W-1:0]  radio_retry_ms;
        logic [TS_W-1:0]  internet_retry_ms;
        logic [TS_W-1:0]  internet_check_ms;
        logic [TS_W-1:0]  broker_retry_ms;
        logic [TS_W-1:0]  watchdog_ms;
        logic [CNT_W-1:0] broker_fail_limit;
        logic [CNT_W-1:0] radio_fail_limit;
        logic [CNT_W-1:0] broker_total_limit;
    } t_cfg;

    typedef struct packed {
        logic [LINK_W-1:0] link_state;
        logic [TS_W-1:0]   last_radio_try;
        logic [TS_W-1:0]   last_internet_test;
        logic [TS_W-1:0]   last_broker_try;
        logic [TS_W-1:0]   last_health;
        logic [TS_W-1:0]   last_publish_ok;
        logic [CNT_W-1:0]  radio_fail_run;
        logic [CNT_W-1:0]  broker_fail_run;
        logic [CNT_W-1:0]  broker_fail_total;
    } t_state;

    typedef struct packed {
        logic              broker_connect_ok;
        logic              internet_ok;
        logic              modem_reboot_ok;
        logic              radio_connect_ok;
        logic              broker_up;
        logic              radio_up;
        logic [TS_W-1:0]   now_ms;
        logic [CMD_W-1:0]  cmd;
    } t_item;

    // packed with conn_state in the lowest bits
    typedef struct packed {
        logic              broker_ready;
        logic              internet_ready;
        logic              health_report;
        logic              restart_request;
        logic              try_broker_connect;
        logic              try_internet_test;
        logic              try_modem_reboot;
        logic              try_radio_connect;
        logic [LINK_W-1:0] conn_state;
    } t_result;

    localparam int unsigned RESULT_W = $bits(t_result);

    function automatic logic is_due(input logic [TS_W-1:0] now,
                                    input logic [TS_W-1:0] last,
                                    input logic [TS_W-1:0] iv);
        logic [TS_W-1:0] diff;
        diff = now - last;
        return (last == '0) || (diff >= iv);
    endfunction

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        return (v == CNT_MAX) ? v : v + CNT_W'(1);
    endfunction

endpackage

[hdl/lrs_step.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrs_step
// Next state and result of one event, given the current supervisor state.
// ----------------------------------------------------------------------------
module lrs_step #(
    parameter logic [lrs_pkg::TS_W-1:0] HEALTH_IV_MS = lrs_pkg::HEALTH_INTERVAL_MS
) (
    input  lrs_pkg::t_state  i_state,
    input  lrs_pkg::t_cfg    i_cfg,
    input  lrs_pkg::t_item   i_item,
    output lrs_pkg::t_state  o_state,
    output lrs_pkg::t_result o_result
);
    import lrs_pkg::*;

    logic [CNT_W-1:0] radio_run_inc;
    logic [CNT_W-1:0] broker_run_inc;
    logic [CNT_W-1:0] broker_tot_inc;
    logic             radio_due;
    logic             inet_due;
    logic             broker_due;
    logic             check_due;
    logic             wdog_due;
    logic             health_due;

    assign radio_run_inc  = sat_inc(i_state.radio_fail_run);
    assign broker_run_inc = sat_inc(i_state.broker_fail_run);
    assign broker_tot_inc = sat_inc(i_state.broker_fail_total);

    assign radio_due  = is_due(i_item.now_ms, i_state.last_radio_try, i_cfg.radio_retry_ms);
    assign inet_due   = is_due(i_item.now_ms, i_state.last_internet_test,
                               i_cfg.internet_retry_ms);
    assign broker_due = is_due(i_item.now_ms, i_state.last_broker_try, i_cfg.broker_retry_ms);
    assign check_due  = is_due(i_item.now_ms, i_state.last_internet_test,
                               i_cfg.internet_check_ms);
    assign wdog_due   = is_due(i_item.now_ms, i_state.last_publish_ok, i_cfg.watchdog_ms);
    assign health_due = is_due(i_item.now_ms, i_state.last_health, HEALTH_IV_MS);

    always_comb begin
        o_state  = i_state;
        o_result = '0;
        case (i_item.cmd)
            CMD_BEGIN: begin
                if (i_item.radio_up) begin
                    o_state.link_state         = LINK_INET_DOWN;
                    o_state.last_internet_test = '0;
                end else begin
                    o_state.link_state     = LINK_RADIO_DOWN;
                    o_state.last_radio_try = '0;
                end
                o_state.last_publish_ok = i_item.now_ms;
            end
            CMD_PUBLISH: begin
                o_state.last_publish_ok = i_item.now_ms;
            end
            CMD_TICK: begin
                case (i_state.link_state)
                    LINK_RADIO_DOWN: begin
                        if (radio_due) begin
                            o_state.last_radio_try     = i_item.now_ms;
                            o_result.try_radio_connect = 1'b1;
                            if (i_item.radio_connect_ok) begin
                                o_state.link_state         = LINK_INET_DOWN;
                                o_state.last_internet_test = '0;
                                o_state.last_broker_try    = '0;
                                o_state.radio_fail_run     = '0;
                            end else begin
                                o_state.radio_fail_run = radio_run_inc;
                                // escalate to a modem reboot once the run reaches the limit
                                if (radio_run_inc >= i_cfg.radio_fail_limit) begin
                                    o_result.try_modem_reboot = 1'b1;
                                    if (i_item.modem_reboot_ok) begin
                                        o_state.link_state         = LINK_INET_DOWN;
                                        o_state.last_internet_test = '0;
                                        o_state.last_broker_try    = '0;
                                        o_state.radio_fail_run     = '0;
                                    end
                                end
                            end
                        end
                    end
                    LINK_INET_DOWN: begin
                        if (!i_item.radio_up) begin
                            o_state.link_state     = LINK_RADIO_DOWN;
                            o_state.last_radio_try = '0;
                        end else if (inet_due) begin
                            o_state.last_internet_test = i_item.now_ms;
                            o_result.try_internet_test = 1'b1;
                            if (i_item.internet_ok) begin
                                o_state.link_state      = LINK_BROKER_DOWN;
                                o_state.last_broker_try = '0;
                                o_state.broker_fail_run = '0;
                            end
                        end
                    end
                    LINK_BROKER_DOWN: begin
                        if (!i_item.radio_up) begin
                            o_state.link_state     = LINK_RADIO_DOWN;
                            o_state.last_radio_try = '0;
                        end else if (broker_due) begin
                            o_state.last_broker_try     = i_item.now_ms;
                            o_result.try_broker_connect = 1'b1;
                            if (i_item.broker_connect_ok) begin
                                o_state.link_state      = LINK_UP;
                                o_state.broker_fail_run = '0;
                            end else begin
                                o_state.broker_fail_run   = broker_run_inc;
                                o_state.broker_fail_total = broker_tot_inc;
                                if (broker_run_inc >= i_cfg.broker_fail_limit) begin
                                    o_state.link_state         = LINK_INET_DOWN;
                                    o_state.last_internet_test = '0;
                                    o_state.broker_fail_run    = '0;
                                end
                                if (broker_tot_inc >= i_cfg.broker_total_limit) begin
                                    o_result.restart_request = 1'b1;
                                end
                            end
                        end
                    end
                    LINK_UP: begin
                        if (!i_item.radio_up) begin
                            o_state.link_state     = LINK_RADIO_DOWN;
                            o_state.last_radio_try = '0;
                        end else if (!i_item.broker_up) begin
                            o_state.link_state      = LINK_BROKER_DOWN;
                            o_state.last_broker_try = '0;
                            o_state.broker_fail_run = '0;
                        end else if (check_due && !i_item.internet_ok) begin
                            // failed periodic check drops out before watchdog and health
                            o_result.try_internet_test = 1'b1;
                            o_state.link_state         = LINK_INET_DOWN;
                            o_state.last_internet_test = '0;
                        end else begin
                            if (check_due) begin
                                o_result.try_internet_test = 1'b1;
                                o_state.last_internet_test = i_item.now_ms;
                            end
                            o_result.restart_request = wdog_due;
                            if (health_due) begin
                                o_state.last_health    = i_item.now_ms;
                                o_result.health_report = 1'b1;
                            end
                        end
                    end
                    default: begin
                        o_state = i_state;
                    end
                endcase
            end
            default: begin
                o_state = i_state;
            end
        endcase

        o_result.conn_state     = o_state.link_state;
        o_result.internet_ready = o_state.link_state[1];
        o_result.broker_ready   = (o_state.link_state == LINK_UP) && i_item.broker_up;
    end

endmodule

[hdl/link_recovery_supervisor.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// link_recovery_supervisor
// Four-state radio / internet / broker recovery supervisor with retry
// pacing, failure escalation, publish watchdog and health reporting.
// ----------------------------------------------------------------------------
//  channel   dir  beat contents (lowest bit first)
//  s_axis    in   tuser: cmd[1:0]; tdata: now_ms, radio_up, broker_up,
//                 radio_connect_ok, modem_reboot_ok, internet_ok, broker_connect_ok
//  m_axis    out  tdata: conn_state, try_radio_connect, try_modem_reboot,
//                 try_internet_test, try_broker_connect, restart_request,
//                 health_report, internet_ready, broker_ready
//  cfg       in   write enable, register index, write data; no read-back
//
// one beat per cycle sustained while m_axis is ready; an accepted input beat
// passes the input register, then step logic into the result register.
// supervisor state updates in the same edge that loads the result register.
// reset clears the link state, timers and counters and restores register
// defaults. a stalled result holds the step; one more input beat is absorbed.
// ----------------------------------------------------------------------------
module link_recovery_supervisor #(
    parameter logic [lrs_pkg::TS_W-1:0] HEALTH_IV_MS = lrs_pkg::HEALTH_INTERVAL_MS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // now_ms, radio_up, broker_up, radio_connect_ok, modem_reboot_ok,
    // internet_ok, broker_connect_ok, zero fill
    input  logic [lrs_pkg::S_TDATA_W-1:0] s_axis_tdata,
    // cmd
    input  logic [lrs_pkg::S_TUSER_W-1:0] s_axis_tuser,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // conn_state, try_radio_connect, try_modem_reboot, try_internet_test,
    // try_broker_connect, restart_request, health_report, internet_ready,
    // broker_ready, zero fill
    output logic [lrs_pkg::M_TDATA_W-1:0] m_axis_tdata,
    input  logic                          i_cfg_wen,
    input  logic [lrs_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [lrs_pkg::CFG_DATA_W-1:0] i_cfg_wdata
);
    import lrs_pkg::*;

    localparam int unsigned ITEM_W = $bits(t_item);

    t_cfg    r_cfg;
    t_state  r_state;
    t_state  n_state;
    t_item   r_in_item;
    logic    r_in_valid;
    t_result r_out;
    t_result n_out;
    logic    r_out_valid;
    logic    advance;

    assign advance       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(M_TDATA_W - RESULT_W){1'b0}}, r_out};

    lrs_step #(
        .HEALTH_IV_MS (HEALTH_IV_MS)
    ) u_step (
        .i_state  (r_state),
        .i_cfg    (r_cfg),
        .i_item   (r_in_item),
        .o_state  (n_state),
        .o_result (n_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.radio_retry_ms     <= RST_RADIO_RETRY;
            r_cfg.internet_retry_ms  <= RST_INET_RETRY;
            r_cfg.internet_check_ms  <= RST_INET_CHECK;
            r_cfg.broker_retry_ms    <= RST_BROKER_RETRY;
            r_cfg.watchdog_ms        <= RST_WATCHDOG;
            r_cfg.broker_fail_limit  <= RST_BROKER_LIMIT;
            r_cfg.radio_fail_limit   <= RST_RADIO_LIMIT;
            r_cfg.broker_total_limit <= RST_BROKER_TOTAL;
        end else if (i_cfg_wen) begin
            case (i_cfg_idx)
                CFG_RADIO_RETRY:  r_cfg.radio_retry_ms     <= i_cfg_wdata;
                CFG_INET_RETRY:   r_cfg.internet_retry_ms  <= i_cfg_wdata;
                CFG_INET_CHECK:   r_cfg.internet_check_ms  <= i_cfg_wdata;
                CFG_BROKER_RETRY: r_cfg.broker_retry_ms    <= i_cfg_wdata;
                CFG_WATCHDOG:     r_cfg.watchdog_ms        <= i_cfg_wdata;
                CFG_BROKER_LIMIT: r_cfg.broker_fail_limit  <= i_cfg_wdata[CNT_W-1:0];
                CFG_RADIO_LIMIT:  r_cfg.radio_fail_limit   <= i_cfg_wdata[CNT_W-1:0];
                CFG_BROKER_TOTAL: r_cfg.broker_total_limit <= i_cfg_wdata[CNT_W-1:0];
                default: begin
                    r_cfg <= r_cfg;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= '0;
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_state     <= n_state;
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_item <= t_item'({s_axis_tdata[ITEM_W-CMD_W-1:0], s_axis_tuser});
        end
        if (advance) begin
            r_out <= n_out;
        end
    end

`ifndef SYNTHESIS
    a_ready_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out.internet_ready == r_out.conn_state[1]))
        else $error("internet_ready disagrees with conn_state");

    a_broker_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.broker_ready) |-> (r_out.conn_state == LINK_UP))
        else $error("broker_ready outside fully connected state");

    a_one_attempt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> $onehot0({r_out.try_radio_connect | r_out.try_modem_reboot,
                                  r_out.try_internet_test, r_out.try_broker_connect}))
        else $error("attempts of more than one layer in one step");

    a_state_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !advance |=> $stable(r_state))
        else $error("supervisor state changed without a step");
`endif

endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the link recovery supervisor. A scoreboard model
// of the four link states, retry pacing, failure escalation, watchdog and
// health timers predicts one status beat per input beat; the status stream
// is compared field by field. Directed beats walk the escalation paths, then
// random event streams run under several register settings with random
// gaps on the input side and random back-pressure on the status side.
// ----------------------------------------------------------------------------
module tb_top;
    import lrs_pkg::*;

    localparam logic [CMD_W-1:0] CMD_UNUSED  = 2'd3;
    localparam int unsigned      CYCLE_LIMIT = 300000;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [S_TDATA_W-1:0]  s_axis_tdata;
    logic [S_TUSER_W-1:0]  s_axis_tuser;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [M_TDATA_W-1:0]  m_axis_tdata;
    logic                  i_cfg_wen;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_wdata;

    link_recovery_supervisor dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_wen     (i_cfg_wen),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    // scoreboard copy of the supervisor
    t_cfg        cfg_shadow;
    t_state      sup;
    t_result     expected_status[$];

    logic [TS_W-1:0] wall_ms;
    int unsigned     send_burst;
    int unsigned     recv_burst;
    int unsigned     items_sent;
    int unsigned     beats_checked;
    int unsigned     cfg_loads;
    int unsigned     mismatches;
    int unsigned     cycle_count;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // model
    // ------------------------------------------------------------------------
    function automatic logic interval_due(input logic [TS_W-1:0] now,
                                          input logic [TS_W-1:0] last,
                                          input logic [TS_W-1:0] interval);
        logic [TS_W-1:0] elapsed;
        elapsed = now - last;
        // zero stamp means never happened
        return (last == '0) || (elapsed >= interval);
    endfunction

    function automatic logic [CNT_W-1:0] bump_sat(input logic [CNT_W-1:0] v);
        return (&v) ? v : v + 1'b1;
    endfunction

    function automatic void radio_restored();
        sup.link_state         = LINK_INET_DOWN;
        sup.last_internet_test = '0;
        sup.last_broker_try    = '0;
        sup.radio_fail_run     = '0;
    endfunction

    function automatic void radio_lost();
        sup.link_state     = LINK_RADIO_DOWN;
        sup.last_radio_try = '0;
    endfunction

    function automatic t_result predict_status(input t_item it);
        t_result r;
        logic    inet_dropped;
        r = '0;
        inet_dropped = 1'b0;
        case (it.cmd)
            CMD_BEGIN: begin
                if (it.radio_up) begin
                    sup.link_state         = LINK_INET_DOWN;
                    sup.last_internet_test = '0;
                end else begin
                    radio_lost();
                end
                sup.last_publish_ok = it.now_ms;
            end
            CMD_PUBLISH: sup.last_publish_ok = it.now_ms;
            CMD_TICK: begin
                case (sup.link_state)
                    LINK_RADIO_DOWN: begin
                        if (interval_due(it.now_ms, sup.last_radio_try,
                                         cfg_shadow.radio_retry_ms)) begin
                            sup.last_radio_try  = it.now_ms;
                            r.try_radio_connect = 1'b1;
                            if (it.radio_connect_ok) begin
                                radio_restored();
                            end else begin
                                sup.radio_fail_run = bump_sat(sup.radio_fail_run);
                                if (sup.radio_fail_run >= cfg_shadow.radio_fail_limit) begin
                                    r.try_modem_reboot = 1'b1;
                                    if (it.modem_reboot_ok) radio_restored();
                                end
                            end
                        end
                    end
                    LINK_INET_DOWN: begin
                        if (!it.radio_up) begin
                            radio_lost();
                        end else if (interval_due(it.now_ms, sup.last_internet_test,
                                                  cfg_shadow.internet_retry_ms)) begin
                            sup.last_internet_test = it.now_ms;
                            r.try_internet_test    = 1'b1;
                            if (it.internet_ok) begin
                                sup.link_state      = LINK_BROKER_DOWN;
                                sup.last_broker_try = '0;
                                sup.broker_fail_run = '0;
                            end
                        end
                    end
                    LINK_BROKER_DOWN: begin
                        if (!it.radio_up) begin
                            radio_lost();
                        end else if (interval_due(it.now_ms, sup.last_broker_try,
                                                  cfg_shadow.broker_retry_ms)) begin
                            sup.last_broker_try  = it.now_ms;
                            r.try_broker_connect = 1'b1;
                            if (it.broker_connect_ok) begin
                                sup.link_state      = LINK_UP;
                                sup.broker_fail_run = '0;
                            end else begin
                                sup.broker_fail_run   = bump_sat(sup.broker_fail_run);
                                sup.broker_fail_total = bump_sat(sup.broker_fail_total);
                                if (sup.broker_fail_run >= cfg_shadow.broker_fail_limit) begin
                                    sup.link_state         = LINK_INET_DOWN;
                                    sup.last_internet_test = '0;
                                    sup.broker_fail_run    = '0;
                                end
                                if (sup.broker_fail_total >= cfg_shadow.broker_total_limit)
                                    r.restart_request = 1'b1;
                            end
                        end
                    end
                    default: begin
                        if (!it.radio_up) begin
                            radio_lost();
                        end else if (!it.broker_up) begin
                            sup.link_state      = LINK_BROKER_DOWN;
                            sup.last_broker_try = '0;
                            sup.broker_fail_run = '0;
                        end else begin
                            if (interval_due(it.now_ms, sup.last_internet_test,
                                             cfg_shadow.internet_check_ms)) begin
                                r.try_internet_test = 1'b1;
                                if (!it.internet_ok) begin
                                    sup.link_state         = LINK_INET_DOWN;
                                    sup.last_internet_test = '0;
                                    inet_dropped           = 1'b1;
                                end else begin
                                    sup.last_internet_test = it.now_ms;
                                end
                            end
                            // a failed periodic test skips watchdog and health
                            if (!inet_dropped) begin
                                if (interval_due(it.now_ms, sup.last_publish_ok,
                                                 cfg_shadow.watchdog_ms))
                                    r.restart_request = 1'b1;
                                if (interval_due(it.now_ms, sup.last_health,
                                                 HEALTH_INTERVAL_MS)) begin
                                    sup.last_health = it.now_ms;
                                    r.health_report = 1'b1;
                                end
                            end
                        end
                    end
                endcase
            end
            default: ;
        endcase
        r.conn_state     = sup.link_state;
        r.internet_ready = (sup.link_state >= LINK_BROKER_DOWN);
        r.broker_ready   = (sup.link_state == LINK_UP) && it.broker_up;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // stream drivers
    // ------------------------------------------------------------------------
    function automatic int unsigned draw_wait(inout int unsigned burst);
        if (burst != 0) begin
            burst = burst - 1;
            return 0;
        end
        if ($urandom_range(0, 29) == 0) begin
            burst = $urandom_range(10, 40);
            return 0;
        end
        return $urandom_range(0, 12);
    endfunction

    task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [TS_W-1:0] now,
                             input logic ru, input logic bu, input logic rok,
                             input logic mok, input logic iok, input logic bok);
        t_item       it;
        int unsigned gap;
        it.cmd               = cmd;
        it.now_ms            = now;
        it.radio_up          = ru;
        it.broker_up         = bu;
        it.radio_connect_ok  = rok;
        it.modem_reboot_ok   = mok;
        it.internet_ok       = iok;
        it.broker_connect_ok = bok;
        gap = draw_wait(send_burst);
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= it.cmd;
        s_axis_tdata  <= {2'b00, it.broker_connect_ok, it.internet_ok, it.modem_reboot_ok,
                          it.radio_connect_ok, it.broker_up, it.radio_up, it.now_ms};
        do @(posedge i_clk); while (!s_axis_tready);
        expected_status.push_back(predict_status(it));
        items_sent++;
    endtask

    // event stream with random content, mostly ticks
    task automatic send_random(input logic [TS_W-1:0] step_max);
        int unsigned      r;
        logic [CMD_W-1:0] cmd;
        r = $urandom_range(0, 99);
        if (r < 2)
            wall_ms = $urandom();
        else if (r < 3)
            wall_ms = '0;
        else
            wall_ms = wall_ms + $urandom_range(0, step_max);
        r = $urandom_range(0, 99);
        if (r < 84)      cmd = CMD_TICK;
        else if (r < 94) cmd = CMD_PUBLISH;
        else if (r < 98) cmd = CMD_BEGIN;
        else             cmd = CMD_UNUSED;
        send_item(cmd, wall_ms,
                  $urandom_range(0, 9) != 0, $urandom_range(0, 6) != 0,
                  $urandom_range(0, 9) < 7, $urandom_range(0, 9) < 7,
                  $urandom_range(0, 9) < 7, $urandom_range(0, 9) < 7);
    endtask

    task automatic wait_quiet();
        s_axis_tvalid <= 1'b0;
        while (expected_status.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic apply_cfg(input logic [31:0] radio_retry, input logic [31:0] inet_retry,
                             input logic [31:0] inet_check, input logic [31:0] broker_retry,
                             input logic [31:0] watchdog, input logic [31:0] broker_limit,
                             input logic [31:0] radio_limit, input logic [31:0] broker_total);
        logic [CFG_DATA_W-1:0] words [8];
        logic [CFG_IDX_W-1:0]  idx;
        wait_quiet();
        words[CFG_RADIO_RETRY]  = radio_retry;
        words[CFG_INET_RETRY]   = inet_retry;
        words[CFG_INET_CHECK]   = inet_check;
        words[CFG_BROKER_RETRY] = broker_retry;
        words[CFG_WATCHDOG]     = watchdog;
        words[CFG_BROKER_LIMIT] = broker_limit;
        words[CFG_RADIO_LIMIT]  = radio_limit;
        words[CFG_BROKER_TOTAL] = broker_total;
        for (int i = 0; i < 8; i++) begin
            idx = CFG_IDX_W'(i);
            i_cfg_wen   <= 1'b1;
            i_cfg_idx   <= idx;
            i_cfg_wdata <= words[i];
            @(posedge i_clk);
            case (idx)
                CFG_RADIO_RETRY:  cfg_shadow.radio_retry_ms     = words[i];
                CFG_INET_RETRY:   cfg_shadow.internet_retry_ms  = words[i];
                CFG_INET_CHECK:   cfg_shadow.internet_check_ms  = words[i];
                CFG_BROKER_RETRY: cfg_shadow.broker_retry_ms    = words[i];
                CFG_WATCHDOG:     cfg_shadow.watchdog_ms        = words[i];
                CFG_BROKER_LIMIT: cfg_shadow.broker_fail_limit  = words[i][CNT_W-1:0];
                CFG_RADIO_LIMIT:  cfg_shadow.radio_fail_limit   = words[i][CNT_W-1:0];
                default:          cfg_shadow.broker_total_limit = words[i][CNT_W-1:0];
            endcase
        end
        i_cfg_wen <= 1'b0;
        cfg_loads++;
    endtask

    function automatic logic [31:0] pick_interval();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r == 0) return '0;
        if (r == 1) return $urandom();
        return $urandom_range(1, 60);
    endfunction

    function automatic logic [31:0] pick_limit();
        int unsigned r;
        logic [31:0] v;
        r = $urandom_range(0, 9);
        if (r == 0) return $urandom_range(0, 255);
        v = $urandom();
        v[7:0] = 8'($urandom_range(1, 6));
        // upper bits are dropped by the 8-bit registers
        if (r == 1) return v;
        return {24'd0, v[7:0]};
    endfunction

    // ------------------------------------------------------------------------
    // status sink and checker
    // ------------------------------------------------------------------------
    initial begin : status_sink
        int unsigned stall;
        m_axis_tready <= 1'b0;
        @(posedge i_clk);
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        forever begin
            stall = draw_wait(recv_burst);
            if (stall != 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
        end
    end

    function automatic void check_field(input string name, input logic [7:0] want,
                                        input logic [7:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge i_clk) begin : status_check
        t_result want;
        t_result got;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = m_axis_tdata[RESULT_W-1:0];
            if (expected_status.size() == 0) begin
                $error("status beat with nothing expected: %h", m_axis_tdata);
                mismatches++;
            end else begin
                want = expected_status.pop_front();
                check_field("conn_state", 8'(want.conn_state), 8'(got.conn_state));
                check_field("try_radio_connect", 8'(want.try_radio_connect),
                            8'(got.try_radio_connect));
                check_field("try_modem_reboot", 8'(want.try_modem_reboot),
                            8'(got.try_modem_reboot));
                check_field("try_internet_test", 8'(want.try_internet_test),
                            8'(got.try_internet_test));
                check_field("try_broker_connect", 8'(want.try_broker_connect),
                            8'(got.try_broker_connect));
                check_field("restart_request", 8'(want.restart_request),
                            8'(got.restart_request));
                check_field("health_report", 8'(want.health_report),
                            8'(got.health_report));
                check_field("internet_ready", 8'(want.internet_ready),
                            8'(got.internet_ready));
                check_field("broker_ready", 8'(want.broker_ready), 8'(got.broker_ready));
                beats_checked++;
            end
        end
    end

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------
    // walk the escalation paths under reset defaults
    task automatic test_directed();
        // radio down: stamp zero reads as never, then retry pacing and reboot
        send_item(CMD_TICK,    32'd0,     0, 0, 0, 0, 0, 0);
        send_item(CMD_TICK,    32'd7,     0, 0, 0, 0, 0, 0);
        send_item(CMD_TICK,    32'd100,   0, 0, 1, 1, 1, 1);
        send_item(CMD_TICK,    32'd30007, 0, 0, 0, 0, 0, 0);
        send_item(CMD_TICK,    32'd60007, 0, 0, 0, 1, 0, 0);
        // internet down: failed test, paced retry, success
        send_item(CMD_TICK,    32'd60010, 1, 0, 0, 0, 0, 0);
        send_item(CMD_TICK,    32'd60020, 1, 0, 0, 0, 1, 0);
        send_item(CMD_TICK,    32'd70010, 1, 0, 0, 0, 1, 0);
        // broker failures back down to internet diagnostics
        send_item(CMD_TICK,    32'd70011, 1, 0, 0, 0, 0, 0);
        send_item(CMD_TICK,    32'd80011, 1, 0, 0, 0, 0, 0);
        send_item(CMD_TICK,    32'd90011, 1, 0, 0, 0, 0, 0);
        send_item(CMD_TICK,    32'd90012, 0, 0, 1, 1, 1, 1);
        send_item(CMD_BEGIN,   32'd100000, 1, 0, 0, 0, 0, 0);
        send_item(CMD_TICK,    32'd100001, 1, 0, 0, 0, 1, 0);
        send_item(CMD_TICK,    32'd100011, 1, 1, 0, 0, 0, 1);
        // fully connected: health, broker drop, watchdog expiry
        send_item(CMD_TICK,    32'd100012, 1, 1, 0, 0, 1, 0);
        send_item(CMD_TICK,    32'd100013, 1, 0, 0, 0, 1, 0);
        send_item(CMD_TICK,    32'd110013, 1, 1, 0, 0, 0, 1);
        send_item(CMD_TICK,    32'd700013, 1, 1, 0, 0, 1, 0);
        send_item(CMD_PUBLISH, 32'hFFFF_FFFF, 1, 1, 1, 1, 1, 1);
        // wrapped timestamp, failed periodic test
        send_item(CMD_TICK,    32'd5,     1, 1, 1, 1, 0, 1);
        send_item(CMD_UNUSED,  32'hA5A5_5A5A, 1, 1, 1, 1, 1, 1);
        send_item(CMD_BEGIN,   32'h8000_0000, 0, 1, 1, 1, 1, 1);
        send_item(CMD_TICK,    32'h8000_0000, 1, 1, 1, 0, 1, 1);
    endtask

    task automatic test_fast_timers();
        apply_cfg(32'd3, 32'd2, 32'd5, 32'd2, 32'd40, 32'd2, 32'd2, 32'd6);
        wall_ms = 32'd1;
        repeat (350) send_random(32'd8);
    endtask

    task automatic test_timer_extremes();
        // zero intervals and zero limits: always due, escalate on every failure
        apply_cfg('0, '0, '0, '0, '0, '0, '0, '0);
        repeat (80) send_random(32'd3);
        // widest intervals and limits
        apply_cfg('1, '1, '1, '1, '1, '1, '1, '1);
        repeat (80) send_random(32'hFFFF_FFFF);
    endtask

    // long failure runs: the radio run and broker total saturate, the broker run hits its limit
    task automatic test_failure_storm();
        apply_cfg('0, '0, 32'd300000, '0, RST_WATCHDOG, 32'd255, 32'd255, 32'd200);
        wall_ms = 32'd1000;
        send_item(CMD_BEGIN, wall_ms, 0, 1, 0, 0, 0, 0);
        repeat (270) begin
            wall_ms = wall_ms + 1;
            send_item(CMD_TICK, wall_ms, 1'($urandom_range(0, 1)),
                      1'($urandom_range(0, 1)), 0, 0,
                      1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        end
        wall_ms = wall_ms + 1;
        send_item(CMD_TICK, wall_ms, 1, 1, 0, 1, 1, 1);
        wall_ms = wall_ms + 1;
        send_item(CMD_TICK, wall_ms, 1, 1, 0, 0, 1, 0);
        repeat (280) begin
            wall_ms = wall_ms + 1;
            send_item(CMD_TICK, wall_ms, 1, 1'($urandom_range(0, 1)),
                      1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 1, 0);
        end
    endtask

    // reset values again, long steps across the timestamp wrap
    task automatic test_slow_wrap();
        apply_cfg(RST_RADIO_RETRY, RST_INET_RETRY, RST_INET_CHECK, RST_BROKER_RETRY,
                  RST_WATCHDOG, {24'd0, RST_BROKER_LIMIT}, {24'd0, RST_RADIO_LIMIT},
                  {24'd0, RST_BROKER_TOTAL});
        wall_ms = 32'hFFF0_0000;
        repeat (200) send_random(32'd40000);
    endtask

    task automatic test_random_settings();
        repeat (4) begin
            apply_cfg(pick_interval(), pick_interval(), pick_interval(), pick_interval(),
                      pick_interval(), pick_limit(), pick_limit(), pick_limit());
            repeat (75) send_random(32'd40);
        end
    endtask

    initial begin
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= '0;
        i_cfg_wen     <= 1'b0;
        i_cfg_idx     <= '0;
        i_cfg_wdata   <= '0;
        cycle_count   = 0;
        items_sent    = 0;
        beats_checked = 0;
        cfg_loads     = 0;
        mismatches    = 0;
        send_burst    = 0;
        recv_burst    = 0;
        wall_ms       = '0;
        sup           = '0;
        cfg_shadow.radio_retry_ms     = RST_RADIO_RETRY;
        cfg_shadow.internet_retry_ms  = RST_INET_RETRY;
        cfg_shadow.internet_check_ms  = RST_INET_CHECK;
        cfg_shadow.broker_retry_ms    = RST_BROKER_RETRY;
        cfg_shadow.watchdog_ms        = RST_WATCHDOG;
        cfg_shadow.broker_fail_limit  = RST_BROKER_LIMIT;
        cfg_shadow.radio_fail_limit   = RST_RADIO_LIMIT;
        cfg_shadow.broker_total_limit = RST_BROKER_TOTAL;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_fast_timers();
        test_timer_extremes();
        test_failure_storm();
        test_slow_wrap();
        test_random_settings();

        wait_quiet();
        repeat (8) @(posedge i_clk);
        $display("covered %0d event beats under %0d register settings plus defaults",
                 items_sent, cfg_loads);
        $display("compared %0d status beats, %0d field mismatches", beats_checked, mismatches);
        if (mismatches == 0 && expected_status.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
